### hw/rtl/gbp_pkg.sv
// Shared types and constants for the GAs branch predictor.
// Holds operation codes, fixed field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int THREAD_W = 2;
    localparam int PC_W     = 64;
    localparam int SHIFT_W  = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNCOND   = 3'd1;
    localparam logic [OP_W-1:0] OP_BTB_MISS = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SQUASH   = 3'd4;

    // Address shift after reset
    localparam logic [SHIFT_W-1:0] INST_SHIFT_RESET = 3'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic execute;
    } gbp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } gbp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/gbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire                                    clk,
    input  wire                                    we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                       wdata,
    input  wire                                    re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gbp_ctrl.sv
// Sequencing state machine for the GAs branch predictor.
// Drives capture, table read, execute and the post-reset table clear.
// Depends on gbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ctrl
    import gbp_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    input  gbp_sts_t  sts,
    output gbp_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // Hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gbp_datapath.sv
// Datapath of the GAs branch predictor: item registers, thread histories,
// pattern table, counter update and output register.
// Depends on gbp_pkg and gbp_ram.
`timescale 1ns / 1ps
`default_nettype none

module gbp_datapath
    import gbp_pkg::*;
#(
    parameter int COUNTER_BITS = 2,
    parameter int HISTORY_BITS = 8,
    parameter int SET_BITS     = 4,
    parameter int THREADS      = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  gbp_cmd_t                 cmd,
    output gbp_sts_t                 sts,
    input  wire                      cfg_we,
    input  wire  [SHIFT_W-1:0]       cfg_shift,
    input  wire  [OP_W-1:0]          in_operation,
    input  wire  [THREAD_W-1:0]      in_thread,
    input  wire  [PC_W-1:0]          in_pc,
    input  wire                      in_taken,
    input  wire                      in_squashed,
    input  wire  [HISTORY_BITS-1:0]  in_saved_history,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic                     out_predict_taken,
    output logic [HISTORY_BITS-1:0]  out_history_snapshot
);

    localparam int IDX_W = SET_BITS + HISTORY_BITS;
    localparam int DEPTH = 1 << IDX_W;
    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};

    logic [SHIFT_W-1:0]      inst_shift_reg;
    logic [OP_W-1:0]         op_reg;
    logic [TW-1:0]           thr_reg;
    logic [PC_W-1:0]         addr_reg;
    logic                    taken_reg;
    logic                    sq_reg;
    logic [HISTORY_BITS-1:0] saved_reg;
    logic [HISTORY_BITS-1:0] hist_reg [THREADS];
    logic [IDX_W-1:0]        clr_addr_reg;
    logic                    out_valid_reg;
    logic                    out_pred_reg;
    logic [HISTORY_BITS-1:0] out_hist_reg;

    logic [THREAD_W:0]       thr_red;
    logic [HISTORY_BITS-1:0] hist_cur;
    logic [HISTORY_BITS-1:0] hist_sel;
    logic [HISTORY_BITS-1:0] hist_next;
    logic [PC_W-1:0]         addr_sh;
    logic [PC_W-1:0]         idx_wide;
    logic [IDX_W-1:0]        idx;
    logic [COUNTER_BITS-1:0] ctr_rd;
    logic [COUNTER_BITS-1:0] ctr_new;
    logic                    pred;
    logic                    upd_write;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [COUNTER_BITS-1:0] ram_wdata;

    // Fold the thread number into the implemented thread count
    always_comb
    begin
        thr_red = {1'b0, in_thread};
        for (int i = 0; i < 4; i++)
        begin
            if (int'(thr_red) >= THREADS)
            begin
                thr_red = thr_red - (THREAD_W + 1)'(THREADS);
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inst_shift_reg <= INST_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            inst_shift_reg <= cfg_shift;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_operation;
            thr_reg   <= TW'(thr_red);
            addr_reg  <= in_pc;
            taken_reg <= in_taken;
            sq_reg    <= in_squashed;
            saved_reg <= in_saved_history;
        end
    end

    // Table index: set from shifted address, row from history or snapshot
    assign hist_cur = hist_reg[thr_reg];
    assign hist_sel = (op_reg == OP_UPDATE) ? saved_reg : hist_cur;
    assign addr_sh  = addr_reg >> inst_shift_reg;
    assign idx_wide = (addr_sh << HISTORY_BITS) | PC_W'(hist_sel);
    assign idx      = idx_wide[IDX_W-1:0];

    // Prediction and saturating counter step
    assign pred = ctr_rd[COUNTER_BITS-1];
    always_comb
    begin
        ctr_new = ctr_rd;
        if (taken_reg)
        begin
            if (ctr_rd != CTR_MAX)
            begin
                ctr_new = ctr_rd + COUNTER_BITS'(1);
            end
        end
        else if (ctr_rd != '0)
        begin
            ctr_new = ctr_rd - COUNTER_BITS'(1);
        end
    end

    // Next history of the selected thread
    always_comb
    begin
        hist_next = hist_cur;
        case (op_reg)
            OP_LOOKUP:   hist_next = HISTORY_BITS'({hist_cur, pred});
            OP_UNCOND:   hist_next = HISTORY_BITS'({hist_cur, 1'b1});
            OP_BTB_MISS: hist_next = hist_cur & ~HISTORY_BITS'(1);
            OP_UPDATE:
            begin
                if (sq_reg)
                begin
                    hist_next = HISTORY_BITS'({saved_reg, taken_reg});
                end
            end
            OP_SQUASH:   hist_next = saved_reg;
            default:     hist_next = hist_cur;
        endcase
    end

    // Advance the histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            hist_reg[thr_reg] <= hist_next;
        end
    end

    // Post-reset clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    assign sts.clear_last = (clr_addr_reg == {IDX_W{1'b1}});

    // Pattern table write select: clear sweep or counter update
    assign upd_write = cmd.execute && (op_reg == OP_UPDATE) && !sq_reg;
    assign ram_we    = cmd.clear_step || upd_write;
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : idx;
    assign ram_wdata = cmd.clear_step ? '0 : ctr_new;

    gbp_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (idx),
        .rdata (ctr_rd)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            out_hist_reg <= hist_cur;
            case (op_reg)
                OP_LOOKUP: out_pred_reg <= pred;
                OP_UNCOND: out_pred_reg <= 1'b1;
                default:   out_pred_reg <= 1'b0;
            endcase
        end
    end

    assign sts.out_free          = !out_valid_reg || out_ready;
    assign out_valid             = out_valid_reg;
    assign out_predict_taken     = out_pred_reg;
    assign out_history_snapshot  = out_hist_reg;

endmodule

`default_nettype wire

### hw/rtl/gas_branch_predictor.sv
// Sequence: an accepted input word is captured, the pattern table is read, then the execute
// step registers the result word; execute waits while the output register is still held.
// Only one word is in flight: no new word is accepted until the last one has executed.
// Reset: histories clear to zero and inst_shift to 2; then the pattern table is swept
// to zero, one entry a cycle, over all 2^(SET_BITS+HISTORY_BITS) entries (4096 by default),
// with s_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module gas_branch_predictor
    import gbp_pkg::*;
#(
    parameter int COUNTER_BITS = 2,
    parameter int HISTORY_BITS = 8,
    parameter int SET_BITS     = 4,
    parameter int THREADS      = 4
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // Configuration: inst_shift
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [SHIFT_W-1:0]                    cfg_data,
    // Input words
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // thread, pc, taken, saved_history (lowest first), zero padded
    input  wire  [((67 + HISTORY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // operation, squashed (lowest first)
    input  wire  [3:0]                            s_tuser,
    // Result words
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // predict_taken, history_snapshot (lowest first), zero padded
    output logic [((1 + HISTORY_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int S_W = ((67 + HISTORY_BITS + 7) / 8) * 8;
    localparam int M_W = ((1 + HISTORY_BITS + 7) / 8) * 8;

    gbp_cmd_t cmd;
    gbp_sts_t sts;
    logic                    out_pred;
    logic [HISTORY_BITS-1:0] out_hist;

    assign cfg_ready = 1'b1;

    gbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbp_datapath #(
        .COUNTER_BITS (COUNTER_BITS),
        .HISTORY_BITS (HISTORY_BITS),
        .SET_BITS     (SET_BITS),
        .THREADS      (THREADS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_we               (cfg_valid && cfg_ready),
        .cfg_shift            (cfg_data),
        .in_operation         (s_tuser[2:0]),
        .in_thread            (s_tdata[1:0]),
        .in_pc                (s_tdata[65:2]),
        .in_taken             (s_tdata[66]),
        .in_squashed          (s_tuser[3]),
        .in_saved_history     (s_tdata[67 +: HISTORY_BITS]),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .out_predict_taken    (out_pred),
        .out_history_snapshot (out_hist)
    );

    // Pack the result word
    assign m_tdata = M_W'({out_hist, out_pred});

`ifndef NO_ASSERTIONS
    // One word in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // A captured word is always followed by a table read
    a_capture_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.read)
        else $error("table read did not follow capture");

    // Execute only into a free output register, and the result then shows
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> sts.out_free)
        else $error("execute while output register occupied");

    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> m_tvalid)
        else $error("result not presented after execute");

    // Clearing sweep never overlaps item processing
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> (!s_tready && !cmd.read && !cmd.execute))
        else $error("clear sweep overlaps item work");
`endif

    // Unused padding bits of the input word
    logic unused_pad;
    assign unused_pad = ^{s_tdata[S_W-1:67 + HISTORY_BITS], 1'b0};

endmodule

`default_nettype wire
